[rtl/core/wmm_pkg.sv]
// Shared types and constants for the window mean and mode block.
// Used by every module under rtl/core; depends on nothing else.
package wmm_pkg;

  localparam int SAMPLE_W  = 8;
  localparam int WLEN_W    = 9;
  localparam int CFG_IDX_W = 2;
  localparam int HIST_BINS = 256;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_VALID  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VALID  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 2'd2;

  // Configuration reset values
  localparam logic [SAMPLE_W-1:0] MIN_VALID_RESET  = 8'd20;
  localparam logic [SAMPLE_W-1:0] MAX_VALID_RESET  = 8'd240;
  localparam logic [WLEN_W-1:0]   WINDOW_LEN_RESET = 9'd256;

  // Request function codes
  localparam logic FUNC_PUSH  = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  typedef struct packed {
    logic                func;
    logic [SAMPLE_W-1:0] sample;
  } req_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] mean_rate;
    logic [SAMPLE_W-1:0] mode_rate;
  } rsp_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;      // request transfer this cycle
    logic setup;       // load window size and read pointer
    logic scan_start;  // start histogram scan and mean division
    logic load_rsp;    // capture result into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic rb_busy;     // histogram rebuild still running
    logic scan_busy;   // mode scan still running
    logic div_busy;    // mean division still running
    logic rsp_free;    // output register can take a result
  } dp_status_t;

endpackage

[rtl/core/wmm_div.sv]
// Restoring divider for the window mean, one quotient bit per cycle.
// Depends on wmm_pkg for the quotient width.
module wmm_div #(
  parameter int CNT_W = 9,
  parameter int SUM_W = 17
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [SUM_W-1:0]             dividend,
  input  logic [CNT_W-1:0]             divisor,
  output logic                         busy,
  output logic [wmm_pkg::SAMPLE_W-1:0] quotient
);
  import wmm_pkg::*;

  localparam int QW    = SAMPLE_W;
  localparam int STEP_W = $clog2(QW);

  logic [SUM_W-1:0]  rem;
  logic [SUM_W-1:0]  dsh;
  logic [STEP_W-1:0] step;
  logic              ge;

  assign ge = (rem >= dsh);

  // Control: run QW steps after start, skip when the divisor is zero
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= (divisor != '0);
      step <= STEP_W'(QW - 1);
    end else if (busy) begin
      if (step == '0) begin
        busy <= 1'b0;
      end else begin
        step <= step - 1'b1;
      end
    end
  end

  // Datapath: the quotient fits QW bits since the mean never exceeds a sample
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dsh      <= SUM_W'({divisor, {(QW - 1){1'b0}}});
      quotient <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      dsh      <= dsh >> 1;
      quotient <= {quotient[QW-2:0], ge};
    end
  end

endmodule

[rtl/core/wmm_datapath.sv]
// Datapath: sample ring, histogram memory, sums, mode scan, divider, output register.
// Depends on wmm_pkg and wmm_div.
module wmm_datapath #(
  parameter int WINDOW_MAX = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  wmm_pkg::req_t                 req,
  input  wmm_pkg::dp_cmd_t              cmd,
  output wmm_pkg::dp_status_t           st,
  input  logic                          cfg_valid,
  input  logic [wmm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wmm_pkg::WLEN_W-1:0]    cfg_data,
  input  logic                          rsp_stall,
  output logic                          rsp_valid,
  output wmm_pkg::rsp_t                 rsp
);
  import wmm_pkg::*;

  localparam int AW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W = CNT_W + SAMPLE_W;
  localparam int NW    = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;
  localparam logic [AW-1:0]    PTR_LAST  = AW'(WINDOW_MAX - 1);
  localparam logic [CNT_W-1:0] FILL_FULL = CNT_W'(WINDOW_MAX);
  localparam logic [NW-1:0]    N_MAX     = NW'(WINDOW_MAX);

  // Configuration registers
  logic [SAMPLE_W-1:0] min_valid;
  logic [SAMPLE_W-1:0] max_valid;
  logic [WLEN_W-1:0]   window_len;

  // Ring state
  logic [SAMPLE_W-1:0] ring [WINDOW_MAX];
  logic [AW-1:0]       write_ptr;
  logic [CNT_W-1:0]    fill_count;
  logic [AW-1:0]       rd_ptr;
  logic [CNT_W-1:0]    remain;

  // Rebuild pipeline
  logic                issue;
  logic                va;
  logic                vb;
  logic [SAMPLE_W-1:0] ring_q;
  logic [SAMPLE_W-1:0] bin_b;
  logic                last_vld;
  logic [SAMPLE_W-1:0] last_bin;
  logic [CNT_W-1:0]    last_cnt;
  logic [CNT_W-1:0]    cnt_c;
  logic                in_range;

  // Histogram
  logic [CNT_W-1:0]     hist [HIST_BINS];
  logic [HIST_BINS-1:0] hist_vld;
  logic [SAMPLE_W-1:0]  hist_raddr;
  logic [CNT_W-1:0]     hist_q;
  logic                 hv_q;

  // Statistics
  logic [SUM_W-1:0] valid_sum;
  logic [CNT_W-1:0] valid_count;

  // Mode scan
  logic                scan_active;
  logic [SAMPLE_W-1:0] scan_bin;
  logic                sv;
  logic [SAMPLE_W-1:0] sbin;
  logic [CNT_W-1:0]    scan_cnt;
  logic [CNT_W-1:0]    best_cnt;
  logic [SAMPLE_W-1:0] mode_q;

  // Window size
  logic [NW-1:0] wl_ext;
  logic [NW-1:0] wl_min1;
  logic [NW-1:0] wl_cap;
  logic [NW-1:0] fill_ext;
  logic [NW-1:0] n_win;

  logic                div_busy;
  logic [SAMPLE_W-1:0] div_q;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      min_valid  <= MIN_VALID_RESET;
      max_valid  <= MAX_VALID_RESET;
      window_len <= WINDOW_LEN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MIN_VALID:  min_valid  <= cfg_data[SAMPLE_W-1:0];
        REG_MAX_VALID:  max_valid  <= cfg_data[SAMPLE_W-1:0];
        REG_WINDOW_LEN: window_len <= cfg_data;
        default: ;
      endcase
    end
  end

  // Push advances the write pointer and fill count; clear empties the window
  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr  <= '0;
      fill_count <= '0;
    end else if (cmd.accept) begin
      if (req.func == FUNC_CLEAR) begin
        write_ptr  <= '0;
        fill_count <= '0;
      end else begin
        write_ptr <= (write_ptr == PTR_LAST) ? '0 : write_ptr + 1'b1;
        if (fill_count != FILL_FULL) begin
          fill_count <= fill_count + 1'b1;
        end
      end
    end
  end

  // Window size: length forced to at least one, capped by depth and fill
  always_comb begin
    wl_ext   = NW'(window_len);
    wl_min1  = (wl_ext == '0) ? NW'(1) : wl_ext;
    wl_cap   = (wl_min1 > N_MAX) ? N_MAX : wl_min1;
    fill_ext = NW'(fill_count);
    n_win    = (wl_cap > fill_ext) ? fill_ext : wl_cap;
  end

  assign issue = (remain != '0);

  // Rebuild control: count down samples, walk the ring backward
  always_ff @(posedge clk) begin
    if (rst) begin
      remain   <= '0;
      va       <= 1'b0;
      vb       <= 1'b0;
      last_vld <= 1'b0;
    end else begin
      if (cmd.setup) begin
        remain <= n_win[CNT_W-1:0];
      end else if (issue) begin
        remain <= remain - 1'b1;
      end
      va       <= issue;
      vb       <= va;
      last_vld <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      rd_ptr <= (write_ptr == '0) ? PTR_LAST : write_ptr - 1'b1;
    end else if (issue) begin
      rd_ptr <= (rd_ptr == '0) ? PTR_LAST : rd_ptr - 1'b1;
    end
  end

  // Ring memory: write on push, registered read during rebuild
  always_ff @(posedge clk) begin
    if (cmd.accept && (req.func == FUNC_PUSH)) begin
      ring[write_ptr] <= req.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      ring_q <= ring[rd_ptr];
    end
  end

  // Histogram read port is shared by rebuild and scan
  assign hist_raddr = scan_active ? scan_bin : ring_q;

  always_ff @(posedge clk) begin
    hist_q <= hist[hist_raddr];
    hv_q   <= hist_vld[hist_raddr];
    bin_b  <= ring_q;
    sbin   <= scan_bin;
  end

  // Increment: forward the count written in the previous cycle to the same bin
  always_comb begin
    if (last_vld && (last_bin == bin_b)) begin
      cnt_c = last_cnt + 1'b1;
    end else begin
      cnt_c = (hv_q ? hist_q : '0) + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (vb) begin
      hist[bin_b] <= cnt_c;
    end
    last_bin <= bin_b;
    last_cnt <= cnt_c;
  end

  // Bin valid bits: an invalid bin reads as zero
  always_ff @(posedge clk) begin
    if (rst || cmd.accept) begin
      hist_vld <= '0;
    end else if (vb) begin
      hist_vld[bin_b] <= 1'b1;
    end
  end

  // Sum and count of in-range samples
  assign in_range = (ring_q >= min_valid) && (ring_q <= max_valid);

  always_ff @(posedge clk) begin
    if (rst || cmd.accept) begin
      valid_sum   <= '0;
      valid_count <= '0;
    end else if (va && in_range) begin
      valid_sum   <= valid_sum + SUM_W'(ring_q);
      valid_count <= valid_count + 1'b1;
    end
  end

  // Mode scan over bins min_valid..max_valid in ascending order
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_active <= 1'b0;
      sv          <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        scan_active <= (min_valid <= max_valid);
      end else if (scan_active && (scan_bin == max_valid)) begin
        scan_active <= 1'b0;
      end
      sv <= scan_active;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_bin <= min_valid;
    end else if (scan_active) begin
      scan_bin <= scan_bin + 1'b1;
    end
  end

  assign scan_cnt = hv_q ? hist_q : '0;

  // Keep the lowest bin with the highest count above one
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      best_cnt <= CNT_W'(1);
      mode_q   <= '0;
    end else if (sv && (scan_cnt > best_cnt)) begin
      best_cnt <= scan_cnt;
      mode_q   <= sbin;
    end
  end

  wmm_div #(
    .CNT_W (CNT_W),
    .SUM_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.scan_start),
    .dividend (valid_sum),
    .divisor  (valid_count),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_rsp) begin
      rsp.mean_rate <= div_q;
      rsp.mode_rate <= mode_q;
    end
  end

  assign st.rb_busy   = issue || va || vb;
  assign st.scan_busy = scan_active || sv;
  assign st.div_busy  = div_busy;
  assign st.rsp_free  = !rsp_valid || !rsp_stall;

endmodule

[rtl/core/wmm_ctrl.sv]
// Controller state machine sequencing accept, rebuild, scan and result.
// Depends on wmm_pkg for the command and status structs.
module wmm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  output wmm_pkg::dp_cmd_t    cmd,
  input  wmm_pkg::dp_status_t st
);
  import wmm_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SETUP   = 3'd1;
  localparam logic [2:0] S_REBUILD = 3'd2;
  localparam logic [2:0] S_SCAN    = 3'd3;
  localparam logic [2:0] S_RESULT  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_stall = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = S_REBUILD;
      end
      S_REBUILD: begin
        if (!st.rb_busy) begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!st.scan_busy && !st.div_busy) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (st.rsp_free) begin
          cmd.load_rsp = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/core/window_mean_and_mode.sv]
// Sliding-window mean and mode of heart-rate samples.
//
// Request channel (req_valid/req_stall/req): func selects push of req.sample
// or clear of the window. Each request yields exactly one response on
// rsp_valid/rsp_stall/rsp carrying the truncated mean of the in-range samples
// and the lowest in-range value seen at least twice with the highest count.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) sets min_valid,
// max_valid and window_len; cfg_ready is always high, write only when idle.
//
// One request is processed at a time. After a transfer the controller sets up
// the window size, rebuilds the histogram of the n samples in the window (walking
// the ring through one histogram read-modify-write per cycle), then scans the
// m = max_valid - min_valid + 1 bins while the 8-step mean divider runs alongside.
// The next request is taken the cycle after the response is loaded; if the
// receiver stalls, the following result waits in the datapath while the
// controller stays in S_RESULT until the output register frees up.
// Reset restores the register defaults and empties the window; no memory
// clearing pass is needed. Depends on wmm_pkg, wmm_ctrl, wmm_datapath.
module window_mean_and_mode #(
  parameter int WINDOW_MAX = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  wmm_pkg::req_t                 req,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output wmm_pkg::rsp_t                 rsp,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wmm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wmm_pkg::WLEN_W-1:0]    cfg_data
);
  import wmm_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  assign cfg_ready = 1'b1;

  wmm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cmd       (cmd),
    .st        (st)
  );

  wmm_datapath #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .st        (st),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

[rtl/core/wmm_checker.sv]
// Port-level checks for window_mean_and_mode, bound to the top level.
// Depends on wmm_pkg for the response type.
module wmm_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input wmm_pkg::rsp_t rsp,
  input logic          cfg_ready
);
  import wmm_pkg::*;

  logic [2:0] pending;
  logic       req_xfer;
  logic       rsp_xfer;

  assign req_xfer = req_valid && !req_stall;
  assign rsp_xfer = rsp_valid && !rsp_stall;

  // Track requests taken but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (req_xfer && !rsp_xfer) begin
      pending <= pending + 1'b1;
    end else if (rsp_xfer && !req_xfer) begin
      pending <= pending - 1'b1;
    end
  end

  // Hold a stalled response
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  // One request at a time: stall right after a transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_xfer |=> req_stall)
    else $error("request taken while another is in progress");

  // No response without a request behind it
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 3'd0)
    else $error("response without pending request");

  // At most one in work and one in the output register
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd2)
    else $error("too many requests outstanding");

  // Configuration port never back-pressures
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind window_mean_and_mode wmm_checker u_wmm_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp),
  .cfg_ready (cfg_ready)
);

[tb/window_mean_and_mode_tb.sv]
// Self-checking testbench for window_mean_and_mode: random and directed sample
// traffic, checked against a sliding-window mean/mode predictor kept here.
// Depends on wmm_pkg and the window_mean_and_mode RTL only.
module window_mean_and_mode_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wmm_pkg::*;

  localparam int RING_DEPTH      = 256;
  localparam int WATCHDOG_LIMIT  = 20000;
  localparam int HOLD_OFF_CYCLES = 3000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int END_TAIL        = 600;

  // Index outside the register map; writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // Expected mean/mode of the most recent samples, one entry per request
  class window_stats_board;
    logic [SAMPLE_W-1:0] ring [RING_DEPTH];
    int unsigned         wr_ptr;
    int unsigned         fill;
    logic [SAMPLE_W-1:0] lo_bpm;
    logic [SAMPLE_W-1:0] hi_bpm;
    logic [WLEN_W-1:0]   win_len;
    rsp_t                expected_stats [$];
    int unsigned         mismatches;
    int unsigned         checked;

    function new();
      lo_bpm  = MIN_VALID_RESET;
      hi_bpm  = MAX_VALID_RESET;
      win_len = WINDOW_LEN_RESET;
      wr_ptr  = 0;
      fill    = 0;
      foreach (ring[i]) ring[i] = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [WLEN_W-1:0] val);
      case (idx)
        REG_MIN_VALID:  lo_bpm = val[SAMPLE_W-1:0];
        REG_MAX_VALID:  hi_bpm = val[SAMPLE_W-1:0];
        REG_WINDOW_LEN: win_len = val;
        default: ;
      endcase
    endfunction

    // Update the ring, then rebuild the window statistics from it
    function void note_request(req_t r);
      int unsigned hist [HIST_BINS];
      int unsigned span;
      int unsigned total;
      int unsigned hits;
      int unsigned top;
      int unsigned mean;
      int unsigned mode;
      int          v;
      rsp_t        s;
      if (r.func == FUNC_CLEAR) begin
        foreach (ring[i]) ring[i] = '0;
        wr_ptr = 0;
        fill   = 0;
      end else begin
        ring[wr_ptr] = r.sample;
        wr_ptr = (wr_ptr + 1) % RING_DEPTH;
        if (fill < RING_DEPTH) fill++;
      end

      // Clamp the window to [1, depth], then to what was pushed since a clear
      span = (win_len == 0) ? 1 : win_len;
      if (span > RING_DEPTH) span = RING_DEPTH;
      if (span > fill) span = fill;

      foreach (hist[i]) hist[i] = 0;
      total = 0;
      hits  = 0;
      for (int k = 1; k <= span; k++) begin
        v = ring[(wr_ptr + RING_DEPTH - k) % RING_DEPTH];
        hist[v]++;
        if (v >= lo_bpm && v <= hi_bpm) begin
          total += v;
          hits++;
        end
      end
      mean = (hits != 0) ? total / hits : 0;

      // Lowest in-range value with the highest count, at least two
      top  = 1;
      mode = 0;
      for (int b = lo_bpm; b <= hi_bpm; b++) begin
        if (hist[b] > top) begin
          top  = hist[b];
          mode = b;
        end
      end

      s.mean_rate = mean[SAMPLE_W-1:0];
      s.mode_rate = mode[SAMPLE_W-1:0];
      expected_stats.push_back(s);
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (expected_stats.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual mean %0d mode %0d",
                 $time, got.mean_rate, got.mode_rate);
        mismatches++;
        return;
      end
      want = expected_stats.pop_front();
      checked++;
      if (got.mean_rate !== want.mean_rate) begin
        $display("%0t: mean_rate mismatch: expected %0d, actual %0d",
                 $time, want.mean_rate, got.mean_rate);
        mismatches++;
      end
      if (got.mode_rate !== want.mode_rate) begin
        $display("%0t: mode_rate mismatch: expected %0d, actual %0d",
                 $time, want.mode_rate, got.mode_rate);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_stats.size();
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  req_t                 req       = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  rsp_t                 rsp;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WLEN_W-1:0]    cfg_data  = '0;

  window_stats_board board = new();

  int send_idle_pct = 0;
  int rsp_stall_pct = 0;
  int rsp_hold_req  = 0;
  int n_pushes      = 0;
  int n_clears      = 0;
  int n_settings    = 0;

  window_mean_and_mode #(
    .WINDOW_MAX(RING_DEPTH)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receive results; stall at random or hold off for a requested stretch
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) board.check_result(rsp);
      if (rsp_hold_req > 0) begin
        hold_left    = rsp_hold_req;
        rsp_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
    end
  end

  // End the run if no transfer of any kind happens for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: watchdog expired after %0d cycles without a transfer", $time, quiet);
    $display("Some tests failed");
    $finish;
  end

  // Offer one request; idle first at random, hold until the transfer
  task automatic send_request(input req_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
    board.note_request(r);
    if (r.func == FUNC_CLEAR) n_clears++;
    else n_pushes++;
  endtask

  task automatic push_sample(input logic [SAMPLE_W-1:0] s);
    req_t r;
    r.func   = FUNC_PUSH;
    r.sample = s;
    send_request(r);
  endtask

  task automatic clear_cmd(input logic [SAMPLE_W-1:0] s);
    req_t r;
    r.func   = FUNC_CLEAR;
    r.sample = s;
    send_request(r);
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WLEN_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, val);
  endtask

  // Reprogram the block while idle, then stream random pushes and occasional clears,
  // samples clustered around the valid range so that modes and means both show up
  task automatic run_phase(input logic [SAMPLE_W-1:0] lo, input logic [SAMPLE_W-1:0] hi,
                           input logic [WLEN_W-1:0] wlen, input int idle_pct,
                           input int stall_pct, input int n_items,
                           input bit hold_mid, input bit pause_mid);
    req_t r;
    int   pick;
    int   near;
    logic [SAMPLE_W-1:0] base;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_MIN_VALID, {1'($urandom_range(1)), lo});
    write_reg(REG_MAX_VALID, {1'($urandom_range(1)), hi});
    write_reg(REG_WINDOW_LEN, wlen);
    write_reg(REG_SPARE, WLEN_W'($urandom_range(511)));
    cfg_valid <= 1'b0;
    n_settings++;
    send_idle_pct = idle_pct;
    rsp_stall_pct = stall_pct;

    near = (hi >= lo) ? hi - lo : lo - hi;
    base = (hi >= lo) ? lo : hi;
    for (int i = 0; i < n_items; i++) begin
      if (hold_mid && i == n_items / 4) rsp_hold_req = HOLD_OFF_CYCLES;
      if (pause_mid && i == n_items / 2) wait_drained();
      r.func = ($urandom_range(99) < 4) ? FUNC_CLEAR : FUNC_PUSH;
      pick = $urandom_range(99);
      if (pick < 60)
        r.sample = base + SAMPLE_W'($urandom_range((near < 5) ? near : 5));
      else if (pick < 75)
        r.sample = pick[0] ? lo : hi;
      else if (pick < 85)
        r.sample = pick[0] ? lo - 8'd1 : hi + 8'd1;
      else
        r.sample = SAMPLE_W'($urandom_range(255));
      send_request(r);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: range edges, ties, clears with junk samples, at reset settings
    push_sample(8'd0);
    push_sample(8'd255);
    push_sample(8'd19);
    push_sample(8'd20);
    push_sample(8'd240);
    push_sample(8'd241);
    push_sample(8'd20);
    push_sample(8'd240);
    push_sample(8'd100);
    push_sample(8'd100);
    push_sample(8'd100);
    clear_cmd(8'hFF);
    push_sample(8'd50);
    push_sample(8'd60);
    push_sample(8'd60);
    push_sample(8'd50);
    push_sample(8'h55);
    push_sample(8'hAA);
    push_sample(8'hAA);
    clear_cmd(8'h00);
    push_sample(8'd1);
    push_sample(8'd1);

    // Random phases: small windows mostly, the full window only briefly
    run_phase(8'd60,  8'd90,  9'd16,  0,  0,  250, 1'b0, 1'b0);
    run_phase(8'd100, 8'd110, 9'd8,   68, 0,  200, 1'b0, 1'b0);
    run_phase(8'd0,   8'd40,  9'd0,   0,  68, 150, 1'b0, 1'b0);
    run_phase(8'd40,  8'd70,  9'd32,  29, 29, 200, 1'b1, 1'b0);
    run_phase(8'd0,   8'd255, 9'd256, 0,  0,  60,  1'b0, 1'b0);
    run_phase(8'd200, 8'd100, 9'd20,  68, 0,  100, 1'b0, 1'b0);
    run_phase(8'd128, 8'd128, 9'd5,   0,  68, 150, 1'b0, 1'b0);
    run_phase(8'd250, 8'd255, 9'd511, 29, 29, 100, 1'b0, 1'b0);
    run_phase(8'd70,  8'd80,  9'd3,   0,  0,  250, 1'b0, 1'b1);
    run_phase(8'd0,   8'd0,   9'd10,  68, 0,  100, 1'b0, 1'b0);
    run_phase(8'd30,  8'd62,  9'd64,  0,  68, 150, 1'b0, 1'b0);
    run_phase(8'd20,  8'd240, 9'd2,   29, 29, 100, 1'b0, 1'b0);

    // Drain, then watch for stray results
    wait_drained();
    repeat (END_TAIL) @(posedge clk);

    $display("Sent %0d pushes and %0d clears across %0d register settings.",
             n_pushes, n_clears, n_settings);
    $display("Checked %0d results, %0d mismatches.", board.checked, board.mismatches);
    if (board.mismatches == 0 && board.pending() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
